// ===== rtl/ecjm_pkg.sv =====
// Shared types and constants for the eye crossing jitter measure block
package ecjm_pkg;

  // eye bitmap geometry
  localparam int Width  = 512;
  localparam int Height = 256;

  localparam int ColW = 9;
  localparam int RowW = 8;
  localparam int PixW = 8;
  localparam int UiW  = 24;

  // center column and the two tracked sides
  localparam logic [ColW-1:0] CenterCol = ColW'(Width / 2);
  localparam logic [ColW-1:0] LeftFirst = ColW'(1);
  localparam logic [ColW-1:0] RightLast = ColW'(2 * (Width / 2) - 1);
  localparam logic [ColW-1:0] ColMax    = ColW'(Width - 1);

  // horizontal band about the vertical center
  localparam logic [RowW-1:0] BandLo = RowW'(Height / 2 - (Height / 20) / 2);
  localparam logic [RowW-1:0] BandHi = RowW'(Height / 2 + (Height / 20) / 2);

  // unit interval after reset
  localparam logic [UiW-1:0] UiReset = UiW'(1000);

  // one eye pixel request
  typedef struct packed {
    logic [ColW-1:0] column;
    logic [RowW-1:0] pixel_row;
    logic [15:0]     density;
    logic            frame_end;
  } pix_req_t;

  // one jitter result
  typedef struct packed {
    logic [UiW-1:0]  jitter_ps;
    logic [PixW-1:0] jitter_pixels;
    logic            edge_found;
  } jit_res_t;

  // wider crossing band, clamped
  typedef struct packed {
    logic [PixW-1:0] pix;
    logic            found;
  } band_t;

endpackage

// ===== rtl/ecjm_track.sv =====
// Edge trackers for both sides of the eye and the crossing band width
module ecjm_track (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              upd_i,
  input  ecjm_pkg::pix_req_t req_i,
  output ecjm_pkg::band_t   band_o
);

  logic [ecjm_pkg::ColW-1:0] li_q, lo_q, ri_q, ro_q;
  logic [ecjm_pkg::ColW-1:0] li_d, lo_d, ri_d, ro_d;
  logic                      hit, in_left, in_right;
  logic signed [ecjm_pkg::ColW:0] wl, wr, wmax;

  // pixel qualification
  assign hit = (req_i.density != 16'd0) &&
               (req_i.pixel_row >= ecjm_pkg::BandLo) &&
               (req_i.pixel_row <= ecjm_pkg::BandHi);
  assign in_left  = (req_i.column >= ecjm_pkg::LeftFirst) &&
                    (req_i.column <= ecjm_pkg::CenterCol);
  assign in_right = (req_i.column >= ecjm_pkg::CenterCol) &&
                    (req_i.column <= ecjm_pkg::RightLast);

  // tracker updates with this pixel
  always_comb begin
    li_d = li_q;
    lo_d = lo_q;
    ri_d = ri_q;
    ro_d = ro_q;
    if (hit && in_left) begin
      if (req_i.column > li_q) li_d = req_i.column;
      if (req_i.column < lo_q) lo_d = req_i.column;
    end
    if (hit && in_right) begin
      if (req_i.column < ri_q) ri_d = req_i.column;
      if (req_i.column > ro_q) ro_d = req_i.column;
    end
  end

  // widths from the updated trackers
  assign wl   = $signed({1'b0, li_d}) - $signed({1'b0, lo_d});
  assign wr   = $signed({1'b0, ro_d}) - $signed({1'b0, ri_d});
  assign wmax = (wl > wr) ? wl : wr;

  assign band_o.found = ~wmax[ecjm_pkg::ColW];
  assign band_o.pix   = wmax[ecjm_pkg::ColW] ? '0 : wmax[ecjm_pkg::PixW-1:0];

  // tracker registers, cleared after a frame ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      li_q <= '0;
      lo_q <= ecjm_pkg::ColMax;
      ri_q <= ecjm_pkg::ColMax;
      ro_q <= '0;
    end else if (upd_i) begin
      if (req_i.frame_end) begin
        li_q <= '0;
        lo_q <= ecjm_pkg::ColMax;
        ri_q <= ecjm_pkg::ColMax;
        ro_q <= '0;
      end else begin
        li_q <= li_d;
        lo_q <= lo_d;
        ri_q <= ri_d;
        ro_q <= ro_d;
      end
    end
  end

endmodule

// ===== rtl/ecjm_scale.sv =====
// Band width register and picosecond scaling into the result register
module ecjm_scale (
  input  logic                        clk_i,
  input  logic                        mid_en_i,
  input  logic                        out_en_i,
  input  ecjm_pkg::band_t             band_i,
  input  logic [ecjm_pkg::UiW-1:0]    ui_i,
  output ecjm_pkg::jit_res_t          res_o
);

  ecjm_pkg::band_t    band_q;
  ecjm_pkg::jit_res_t res_q, res_d;
  logic [ecjm_pkg::UiW+ecjm_pkg::PixW-1:0] prod;

  // 2*ui*pix/512 is ui*pix shifted right by eight
  assign prod = ecjm_pkg::UiW'(ui_i) * band_q.pix;

  always_comb begin
    res_d.jitter_ps     = prod[ecjm_pkg::UiW+ecjm_pkg::PixW-1:ecjm_pkg::PixW];
    res_d.jitter_pixels = band_q.pix;
    res_d.edge_found    = band_q.found;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (mid_en_i) band_q <= band_i;
    if (out_en_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== rtl/eye_crossing_jitter_measure_top.sv =====
// Top level of the eye crossing jitter measure block
//
// Eye pixels come in on the pix channel (valid/stall), one request per cycle,
// in any order. A pixel in the center row band with nonzero density moves the
// inner and outer edge trackers on its side of the center column. A request
// with frame_end set is used like any other pixel and then yields one result
// on the res channel: the wider crossing band in pixels, in picoseconds as
// 2*ui*pixels/512, and a flag that is low when the band was clamped to zero.
// The trackers clear after that request; other requests give no result.
// A frame_end request taken into the input register goes through the tracker
// and band register and then the result register before it is shown on res.
// Throughput: one request per cycle while pix_stall_o is low; the tracker
// update is the single step per pixel and the scaling multiply sits in its
// own register stage. The user must write the unit interval register
// (cfg_we_i/cfg_wdata_i) only while idle; the block does not enforce it.
// Reset clears the trackers and the valid bits and sets the unit interval to
// 1000 ps. When the receiver stalls, the result register holds; requests keep
// flowing until one result waits on res, a second waits in the band register
// and a third frame_end request sits in the input register, then
// pix_stall_o rises.
module eye_crossing_jitter_measure_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     pix_valid_i,
  input  ecjm_pkg::pix_req_t       pix_i,
  output logic                     pix_stall_o,
  output logic                     res_valid_o,
  output ecjm_pkg::jit_res_t       res_o,
  input  logic                     res_stall_i,
  input  logic                     cfg_we_i,
  input  logic [ecjm_pkg::UiW-1:0] cfg_wdata_i
);

  ecjm_pkg::pix_req_t       in_q;
  ecjm_pkg::band_t          band;
  logic                     in_vld_q, mid_vld_q, out_vld_q;
  logic                     in_go, mid_go, accept;
  logic [ecjm_pkg::UiW-1:0] ui_q;

  // stage advance control
  assign mid_go      = mid_vld_q && (!out_vld_q || !res_stall_i);
  assign in_go       = in_vld_q && (!in_q.frame_end || !mid_vld_q || mid_go);
  assign pix_stall_o = in_vld_q && !in_go;
  assign accept      = pix_valid_i && !pix_stall_o;

  // valid bits and unit interval register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      ui_q      <= ecjm_pkg::UiReset;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (in_go) begin
        in_vld_q <= 1'b0;
      end
      if (in_go && in_q.frame_end) begin
        mid_vld_q <= 1'b1;
      end else if (mid_go) begin
        mid_vld_q <= 1'b0;
      end
      if (mid_go) begin
        out_vld_q <= 1'b1;
      end else if (!res_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) ui_q <= cfg_wdata_i;
    end
  end

  // input request register
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= pix_i;
  end

  ecjm_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (in_go),
    .req_i  (in_q),
    .band_o (band)
  );

  ecjm_scale u_scale (
    .clk_i    (clk_i),
    .mid_en_i (in_go && in_q.frame_end),
    .out_en_i (mid_go),
    .band_i   (band),
    .ui_i     (ui_q),
    .res_o    (res_o)
  );

  assign res_valid_o = out_vld_q;

endmodule

// ===== tb/tb_eye_crossing_jitter_measure_top.sv =====
// Self-checking testbench for the eye crossing jitter measure block
`timescale 1ns / 100ps

module tb_eye_crossing_jitter_measure_top;

  localparam int MaxGap       = 12;
  localparam int SettleCycles = 6;
  localparam int DrainLimit   = 20000;
  localparam int MaxReports   = 60;
  localparam int LongHold     = 400;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     pix_valid_i;
  ecjm_pkg::pix_req_t       pix_i;
  logic                     pix_stall_o;
  logic                     res_valid_o;
  ecjm_pkg::jit_res_t       res_o;
  logic                     res_stall_i;
  logic                     cfg_we_i;
  logic [ecjm_pkg::UiW-1:0] cfg_wdata_i;

  // expected behavior: unit interval, edge trackers, queued results
  logic [ecjm_pkg::UiW-1:0] ui_ps;
  int                       lft_inner, lft_outer, rgt_inner, rgt_outer;
  ecjm_pkg::jit_res_t       pending_jitter[$];
  int                       err_cnt;

  // idling controls shared by sender and receiver
  bit             tx_idle_on, rx_idle_on;
  int             rx_hold_req, rx_gap_left, rx_hold_left;

  eye_crossing_jitter_measure_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_valid_i),
    .pix_i       (pix_i),
    .pix_stall_o (pix_stall_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .res_stall_i (res_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // run limit
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void clear_edges();
    lft_inner = 0;
    lft_outer = int'(ecjm_pkg::ColMax);
    rgt_inner = int'(ecjm_pkg::ColMax);
    rgt_outer = 0;
  endfunction

  // track one pixel; on frame end queue the wider band and clear
  task automatic measure_pixel(input ecjm_pkg::pix_req_t p);
    int                 col, wl, wr, wmax;
    longint             ps;
    ecjm_pkg::jit_res_t r;
    col = int'(p.column);
    if (p.density != 16'd0 && p.pixel_row >= ecjm_pkg::BandLo &&
        p.pixel_row <= ecjm_pkg::BandHi) begin
      if (col >= int'(ecjm_pkg::LeftFirst) && col <= int'(ecjm_pkg::CenterCol)) begin
        if (col > lft_inner) lft_inner = col;
        if (col < lft_outer) lft_outer = col;
      end
      if (col >= int'(ecjm_pkg::CenterCol) && col <= int'(ecjm_pkg::RightLast)) begin
        if (col < rgt_inner) rgt_inner = col;
        if (col > rgt_outer) rgt_outer = col;
      end
    end
    if (p.frame_end) begin
      wl   = lft_inner - lft_outer;
      wr   = rgt_outer - rgt_inner;
      wmax = (wl > wr) ? wl : wr;
      r.edge_found = (wmax >= 0);
      if (wmax < 0) wmax = 0;
      ps = (2 * longint'(ui_ps) * longint'(wmax)) / ecjm_pkg::Width;
      r.jitter_ps     = (ps > 64'hFF_FFFF) ? '1 : ecjm_pkg::UiW'(ps);
      r.jitter_pixels = (wmax > 255) ? '1 : ecjm_pkg::PixW'(wmax);
      pending_jitter = {pending_jitter, r};
      clear_edges();
    end
  endtask

  function automatic ecjm_pkg::pix_req_t make_pixel(input int col, input int row,
                                                    input int dens, input bit last);
    ecjm_pkg::pix_req_t p;
    p.column    = ecjm_pkg::ColW'(col);
    p.pixel_row = ecjm_pkg::RowW'(row);
    p.density   = 16'(dens);
    p.frame_end = last;
    return p;
  endfunction

  // mostly band hits, with misses, out-of-band rows and edge columns mixed in
  function automatic ecjm_pkg::pix_req_t random_pixel(input bit last);
    ecjm_pkg::pix_req_t p;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      p.pixel_row = ecjm_pkg::RowW'($urandom_range(ecjm_pkg::BandLo, ecjm_pkg::BandHi));
    else
      p.pixel_row = ecjm_pkg::RowW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) p.density = '0;
    else if (pick < 25) p.density = '1;
    else p.density = 16'($urandom);
    case ($urandom_range(0, 9))
      0: p.column = ecjm_pkg::ColW'($urandom_range(0, 2));
      1: p.column = ecjm_pkg::ColW'($urandom_range(int'(ecjm_pkg::CenterCol) - 1,
                                                   int'(ecjm_pkg::CenterCol) + 1));
      2: p.column = ecjm_pkg::ColW'($urandom_range(int'(ecjm_pkg::ColMax) - 2,
                                                   int'(ecjm_pkg::ColMax)));
      default: p.column = ecjm_pkg::ColW'($urandom);
    endcase
    p.frame_end = last;
    return p;
  endfunction

  // offer one pixel request, after a random gap when sender idling is on, and wait for acceptance
  task automatic send_pixel(input ecjm_pkg::pix_req_t p);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      pix_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_valid_i <= 1'b1;
    pix_i       <= p;
    do @(posedge clk_i); while (pix_stall_o);
    measure_pixel(p);
  endtask

  task automatic send_frame(input int npix);
    repeat (npix - 1) send_pixel(random_pixel(1'b0));
    send_pixel(random_pixel(1'b1));
  endtask

  // sender goes quiet until every queued result has come out
  task automatic drain_results();
    int waited;
    waited = 0;
    pix_valid_i <= 1'b0;
    while (pending_jitter.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_ui(input logic [ecjm_pkg::UiW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ui_ps = v;
  endtask

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    err_cnt++;
    if (err_cnt <= MaxReports)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // frames of random length, idling redrawn now and then
  task automatic random_frames(input int items);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_idle_on = $urandom_range(0, 1);
        rx_idle_on = $urandom_range(0, 1);
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 16);
      send_frame(n);
      sent += n;
    end
  endtask

  // frames with no usable hit, or only the center column
  task automatic test_empty_frames();
    send_pixel(make_pixel(0, 128, 16'hFFFF, 1'b1));
    send_pixel(make_pixel(int'(ecjm_pkg::CenterCol), 128, 1, 1'b1));
    send_pixel(make_pixel(300, 255, 16'hFFFF, 1'b1));
    drain_results();
  endtask

  // widest bands on both sides, then each side alone
  task automatic test_band_widths();
    send_pixel(make_pixel(int'(ecjm_pkg::LeftFirst), int'(ecjm_pkg::BandLo), 1, 1'b0));
    send_pixel(make_pixel(int'(ecjm_pkg::CenterCol), int'(ecjm_pkg::BandHi), 16'hFFFF,
                          1'b0));
    send_pixel(make_pixel(int'(ecjm_pkg::ColMax), 128, 7, 1'b1));
    send_pixel(make_pixel(100, 124, 5, 1'b0));
    send_pixel(make_pixel(120, 130, 9, 1'b1));
    send_pixel(make_pixel(400, int'(ecjm_pkg::BandLo), 3, 1'b0));
    send_pixel(make_pixel(300, int'(ecjm_pkg::BandHi), 16'h8000, 1'b1));
    drain_results();
  endtask

  // rows just outside the band and zero density never count
  task automatic test_band_rows();
    send_pixel(make_pixel(50, int'(ecjm_pkg::BandLo) - 1, 16'hFFFF, 1'b0));
    send_pixel(make_pixel(60, int'(ecjm_pkg::BandHi) + 1, 16'hFFFF, 1'b0));
    send_pixel(make_pixel(70, 0, 16'hFFFF, 1'b0));
    send_pixel(make_pixel(400, 128, 0, 1'b0));
    send_pixel(make_pixel(50, int'(ecjm_pkg::BandLo), 0, 1'b1));
    send_pixel(make_pixel(10, int'(ecjm_pkg::BandLo), 1, 1'b0));
    send_pixel(make_pixel(20, int'(ecjm_pkg::BandHi), 1, 1'b1));
    drain_results();
  endtask

  // smallest, largest and zero unit interval
  task automatic test_ui_extremes();
    logic [ecjm_pkg::UiW-1:0] vals[3];
    vals = '{ecjm_pkg::UiW'(1), '1, '0};
    foreach (vals[i]) begin
      write_ui(vals[i]);
      send_pixel(make_pixel(int'(ecjm_pkg::LeftFirst), 128, 1, 1'b0));
      send_pixel(make_pixel(int'(ecjm_pkg::CenterCol), 128, 1, 1'b0));
      send_pixel(make_pixel(int'(ecjm_pkg::ColMax), 128, 1, 1'b1));
      random_frames(150);
      drain_results();
    end
  endtask

  task automatic test_random_ui();
    repeat (3) begin
      write_ui(ecjm_pkg::UiW'($urandom_range(1, 24'hFF_FFFF)));
      random_frames(100);
      drain_results();
    end
  endtask

  // receiver holds off while results pile up behind it
  task automatic test_result_backpressure();
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    rx_hold_req = LongHold;
    repeat (40) send_pixel(random_pixel(1'b1));
    repeat (10) send_frame(3);
    drain_results();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // sender stops mid-run until all results are in, then resumes
  task automatic test_sender_pause();
    write_ui(ecjm_pkg::UiReset);
    random_frames(100);
    drain_results();
    random_frames(100);
    drain_results();
  endtask

  // receiver stall: a random wait after each result, plus any long hold asked for
  always @(posedge clk_i) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (res_valid_o && !res_stall_i)
      rx_gap_left = rx_idle_on ? $urandom_range(0, MaxGap) : 0;
    else if (rx_gap_left > 0)
      rx_gap_left--;
    if (rx_hold_left > 0) rx_hold_left--;
    res_stall_i <= (rx_gap_left > 0) || (rx_hold_left > 0);
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    ecjm_pkg::jit_res_t want;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (pending_jitter.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReports)
          $display("%0t: unexpected result, expected none, got ps %0d pixels %0d found %0d",
                   $time, res_o.jitter_ps, res_o.jitter_pixels, res_o.edge_found);
      end else begin
        want = pending_jitter.pop_front();
        if (res_o.jitter_ps !== want.jitter_ps)
          flag_mismatch("jitter_ps", want.jitter_ps, res_o.jitter_ps);
        if (res_o.jitter_pixels !== want.jitter_pixels)
          flag_mismatch("jitter_pixels", want.jitter_pixels, res_o.jitter_pixels);
        if (res_o.edge_found !== want.edge_found)
          flag_mismatch("edge_found", want.edge_found, res_o.edge_found);
      end
    end
  end

  // main sequence
  initial begin
    rst_ni       = 1'b0;
    pix_valid_i  = 1'b0;
    pix_i        = '0;
    res_stall_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    rx_hold_req  = 0;
    rx_gap_left  = 0;
    rx_hold_left = 0;
    err_cnt      = 0;
    ui_ps        = ecjm_pkg::UiReset;
    clear_edges();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_frames();
    test_band_widths();
    test_band_rows();
    test_ui_extremes();
    test_random_ui();
    test_result_backpressure();
    test_sender_pause();

    drain_results();
    if (pending_jitter.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected results never arrived", $time, pending_jitter.size());
    end
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
